// ===== rtl/kpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared widths, types, register codes and saturation helpers of the
// keyframe path interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;

    localparam int COORD_BITS  = 24;
    localparam int STEP_BITS   = COORD_BITS + 1;
    localparam int REM_BITS    = COORD_BITS + 2;
    localparam int DUR_BITS    = 16;
    localparam int MAX_POINTS  = 16;
    localparam int IDX_BITS    = $clog2(MAX_POINTS);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int PROD_BITS   = REM_BITS + DUR_BITS;
    localparam int MUL_STEPS   = DUR_BITS;
    localparam int DIV_STEPS   = PROD_BITS;
    localparam int MD_CNT_BITS = $clog2(PROD_BITS + 1);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [STEP_BITS-1:0]  step_t;
    typedef logic signed [REM_BITS-1:0]   rem_t;
    typedef logic [DUR_BITS-1:0]          dur_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [CNT_BITS-1:0]          cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        dur_t   dur;
    } keypoint_t;

    typedef enum logic [1:0] {
        CFG_REVERSABLE = 2'd0,
        CFG_START_X    = 2'd1,
        CFG_START_Y    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_WAIT,
        ST_SEC_A,
        ST_SEC_B,
        ST_SEC_C,
        ST_RESP
    } kpi_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_state_t;

    // clamp to the coordinate range: fits when all bits above the sign agree
    function automatic coord_t sat_coord(rem_t v);
        coord_t r;
        if ((&v[REM_BITS-1:COORD_BITS-1]) || !(|v[REM_BITS-1:COORD_BITS-1]))
        begin
            r = v[COORD_BITS-1:0];
        end
        else if (v[REM_BITS-1])
        begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic step_t sat_step(rem_t v);
        step_t r;
        if (v[REM_BITS-1] == v[STEP_BITS-1])
        begin
            r = v[STEP_BITS-1:0];
        end
        else if (v[REM_BITS-1])
        begin
            r = {1'b1, {(STEP_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(STEP_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kpi_muldiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kpi_muldiv
// Bit-serial scale unit: remaining distance times tick over time left.
// Shift-add multiply one tick bit a cycle, then restoring divide one
// quotient bit a cycle, then saturate to the step width.
// ----------------------------------------------------------------------------
module kpi_muldiv (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire kpi_pkg::rem_t  rem,
    input  wire kpi_pkg::dur_t  tick,
    input  wire kpi_pkg::dur_t  divisor,
    output logic                done,
    output kpi_pkg::step_t      quot
);
    import kpi_pkg::*;

    md_state_t               state_reg, state_next;
    logic [MD_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [PROD_BITS-1:0]    acc_reg;
    logic [REM_BITS-1:0]     mag_reg;
    dur_t                    mplier_reg;
    dur_t                    div_reg;
    dur_t                    part_reg;
    logic                    neg_reg;

    logic [REM_BITS:0]       mul_sum;
    logic [DUR_BITS:0]       trial;
    logic [DUR_BITS:0]       diff;
    logic                    fits;
    logic                    big_pos;
    logic                    big_neg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (go)
                begin
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (cnt_reg == MD_CNT_BITS'(MUL_STEPS - 1))
                begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (cnt_reg == MD_CNT_BITS'(DIV_STEPS - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
        cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
    end

    always_comb
    begin
        done = (state_reg == MD_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign mul_sum = {1'b0, acc_reg[PROD_BITS-1:DUR_BITS]}
                   + (mplier_reg[0] ? {1'b0, mag_reg} : '0);
    assign trial   = {part_reg, acc_reg[PROD_BITS-1]};
    assign diff    = trial - {1'b0, div_reg};
    assign fits    = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        case (state_reg)
            MD_IDLE:
            begin
                if (go)
                begin
                    neg_reg    <= rem[REM_BITS-1];
                    mag_reg    <= rem[REM_BITS-1] ? REM_BITS'(-rem) : REM_BITS'(rem);
                    mplier_reg <= tick;
                    div_reg    <= divisor;
                    acc_reg    <= '0;
                    part_reg   <= '0;
                end
            end
            MD_MUL:
            begin
                acc_reg    <= {mul_sum, acc_reg[DUR_BITS-1:1]};
                mplier_reg <= mplier_reg >> 1;
            end
            MD_DIV:
            begin
                part_reg <= fits ? diff[DUR_BITS-1:0] : trial[DUR_BITS-1:0];
                acc_reg  <= {acc_reg[PROD_BITS-2:0], fits};
            end
            default:
            begin
            end
        endcase
    end

    // clamp the quotient magnitude into the signed step range
    assign big_pos = |acc_reg[PROD_BITS-1:COORD_BITS];
    assign big_neg = (|acc_reg[PROD_BITS-1:STEP_BITS])
                  || (acc_reg[COORD_BITS] && (|acc_reg[COORD_BITS-1:0]));

    always_comb
    begin
        if (!neg_reg)
        begin
            quot = big_pos ? {1'b0, {COORD_BITS{1'b1}}} : {1'b0, acc_reg[COORD_BITS-1:0]};
        end
        else
        begin
            quot = big_neg ? {1'b1, {COORD_BITS{1'b0}}} : STEP_BITS'(-acc_reg[STEP_BITS-1:0]);
        end
    end

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == MD_IDLE)
        else $error("scale unit started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == MD_IDLE)
        else $error("scale unit did not return to idle");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == MD_DIV |-> cnt_reg < MD_CNT_BITS'(DIV_STEPS))
        else $error("divide step count overran");

endmodule
`default_nettype wire

// ===== rtl/keyframe_path_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_path_interpolator
// Moves a 2D point along a stored path of up to 16 keypoints, loop or
// ping-pong, one result item per input item.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// for exactly one cycle with done high and cannot be held off, so the
// receiver must take it then. An ignored or swallowed tick goes straight
// to done; so does a load, unless it marks the last keypoint and passes
// through the section states. A moving tick waits on both bit-serial scale
// units (16 multiply steps, then 42 divide steps, x and y in parallel), then
// on the section states if it closes a section. The user must write
// configuration only while busy is low; the block does not enforce it.
module keyframe_path_interpolator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire kpi_pkg::idx_t     point_index,
    input  wire kpi_pkg::coord_t   point_x,
    input  wire kpi_pkg::coord_t   point_y,
    input  wire kpi_pkg::dur_t     point_duration_ms,
    input  wire logic              last_point,
    input  wire kpi_pkg::dur_t     tick_ms,
    input  wire logic              single_shot,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire kpi_pkg::coord_t   cfg_data,
    output logic                   done,
    output kpi_pkg::step_t         step_x,
    output kpi_pkg::step_t         step_y,
    output kpi_pkg::coord_t        position_x,
    output kpi_pkg::coord_t        position_y,
    output logic                   finished,
    output logic                   going_back,
    output kpi_pkg::cnt_t          section_index,
    output logic                   status
);
    import kpi_pkg::*;

    kpi_state_t state_reg, state_next;
    logic       rev_mode_reg;
    coord_t     start_x_reg, start_y_reg;
    cnt_t       pc_reg;
    idx_t       ci_reg;
    logic       rev_reg;
    logic       fin_reg;
    coord_t     begin_x_reg, begin_y_reg;
    coord_t     end_x_reg, end_y_reg;
    coord_t     pos_x_reg, pos_y_reg;
    step_t      dist_x_reg, dist_y_reg;
    dur_t       se_reg;
    dur_t       tick_reg;
    dur_t       dur_reg;
    logic       left_pos_reg;
    step_t      step_x_reg, step_y_reg;
    logic       status_reg;

    keypoint_t  mem [MAX_POINTS];
    keypoint_t  rd_data_reg;
    idx_t       rd_addr;

    logic               accept;
    logic               go;
    logic [DUR_BITS:0]  left;
    rem_t               rem_x, rem_y;
    logic               done_x, done_y;
    step_t              q_x, q_y;
    step_t              p_x, p_y;
    logic [DUR_BITS:0]  se_sum;
    logic               sec_end;
    cnt_t               ci_plus;
    logic               last_sec;

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        state_next = last_point ? ST_SEC_A : ST_RESP;
                    end
                    else if (pc_reg == '0 || (single_shot && fin_reg))
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (done_x)
                begin
                    state_next = sec_end ? ST_SEC_A : ST_RESP;
                end
            end
            ST_SEC_A:
            begin
                state_next = ST_SEC_B;
            end
            ST_SEC_B:
            begin
                state_next = (rev_reg && ci_reg != '0) ? ST_SEC_C : ST_RESP;
            end
            ST_SEC_C:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy    = (state_reg != ST_IDLE);
        done    = (state_reg == ST_RESP);
        go      = (state_reg == ST_CALC);
        rd_addr = (state_reg == ST_SEC_B) ? ci_reg - 1'b1 : ci_reg;
    end

    assign left    = {1'b0, rd_data_reg.dur} - {1'b0, se_reg};
    assign rem_x   = rem_t'(end_x_reg) - rem_t'(begin_x_reg) - rem_t'(dist_x_reg);
    assign rem_y   = rem_t'(end_y_reg) - rem_t'(begin_y_reg) - rem_t'(dist_y_reg);
    assign p_x     = left_pos_reg ? q_x : '0;
    assign p_y     = left_pos_reg ? q_y : '0;
    assign se_sum  = {1'b0, se_reg} + {1'b0, tick_reg};
    assign sec_end = (se_sum >= {1'b0, dur_reg});
    assign ci_plus = {1'b0, ci_reg} + 1'b1;
    assign last_sec = (ci_plus >= pc_reg);

    kpi_muldiv u_scale_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .rem     (rem_x),
        .tick    (tick_reg),
        .divisor (left[DUR_BITS-1:0]),
        .done    (done_x),
        .quot    (q_x)
    );

    kpi_muldiv u_scale_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .rem     (rem_y),
        .tick    (tick_reg),
        .divisor (left[DUR_BITS-1:0]),
        .done    (done_y),
        .quot    (q_y)
    );

    // keypoint store
    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_LOAD)
        begin
            mem[point_index] <= '{x: point_x, y: point_y, dur: point_duration_ms};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rev_mode_reg <= 1'b0;
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            pc_reg       <= '0;
            ci_reg       <= '0;
            rev_reg      <= 1'b0;
            fin_reg      <= 1'b0;
            begin_x_reg  <= '0;
            begin_y_reg  <= '0;
            end_x_reg    <= '0;
            end_y_reg    <= '0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            dist_x_reg   <= '0;
            dist_y_reg   <= '0;
            se_reg       <= '0;
            tick_reg     <= '0;
            dur_reg      <= '0;
            left_pos_reg <= 1'b0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            status_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_REVERSABLE:
                    begin
                        rev_mode_reg <= cfg_data[0];
                    end
                    CFG_START_X:
                    begin
                        start_x_reg <= cfg_data;
                        if (ci_reg == '0 && !rev_reg)
                        begin
                            begin_x_reg <= cfg_data;
                            begin_y_reg <= start_y_reg;
                            pos_x_reg   <= cfg_data;
                            pos_y_reg   <= start_y_reg;
                            dist_x_reg  <= '0;
                            dist_y_reg  <= '0;
                            se_reg      <= '0;
                        end
                    end
                    CFG_START_Y:
                    begin
                        start_y_reg <= cfg_data;
                        if (ci_reg == '0 && !rev_reg)
                        begin
                            begin_x_reg <= start_x_reg;
                            begin_y_reg <= cfg_data;
                            pos_x_reg   <= start_x_reg;
                            pos_y_reg   <= cfg_data;
                            dist_x_reg  <= '0;
                            dist_y_reg  <= '0;
                            se_reg      <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        step_x_reg <= '0;
                        step_y_reg <= '0;
                        status_reg <= 1'b0;
                        if (mode == MODE_LOAD)
                        begin
                            if (last_point)
                            begin
                                // new path: restart, section end comes from slot 0
                                pc_reg      <= {1'b0, point_index} + 1'b1;
                                ci_reg      <= '0;
                                begin_x_reg <= start_x_reg;
                                begin_y_reg <= start_y_reg;
                                pos_x_reg   <= start_x_reg;
                                pos_y_reg   <= start_y_reg;
                                dist_x_reg  <= '0;
                                dist_y_reg  <= '0;
                                rev_reg     <= 1'b0;
                                fin_reg     <= 1'b0;
                                se_reg      <= '0;
                            end
                        end
                        else if (pc_reg == '0)
                        begin
                            status_reg <= 1'b1;
                        end
                        else if (single_shot && fin_reg)
                        begin
                            fin_reg <= 1'b0;
                        end
                        else
                        begin
                            tick_reg <= tick_ms;
                        end
                    end
                end
                ST_CALC:
                begin
                    dur_reg      <= rd_data_reg.dur;
                    left_pos_reg <= !left[DUR_BITS] && (|left[DUR_BITS-1:0]);
                    fin_reg      <= 1'b0;
                end
                ST_WAIT:
                begin
                    if (done_x)
                    begin
                        pos_x_reg <= sat_coord(rem_t'(pos_x_reg) + rem_t'(p_x));
                        pos_y_reg <= sat_coord(rem_t'(pos_y_reg) + rem_t'(p_y));
                        if (!sec_end)
                        begin
                            dist_x_reg <= sat_step(rem_t'(dist_x_reg) + rem_t'(p_x));
                            dist_y_reg <= sat_step(rem_t'(dist_y_reg) + rem_t'(p_y));
                            se_reg     <= se_sum[DUR_BITS-1:0];
                            step_x_reg <= p_x;
                            step_y_reg <= p_y;
                        end
                        else
                        begin
                            se_reg     <= '0;
                            dist_x_reg <= '0;
                            dist_y_reg <= '0;
                            if ((rev_reg && ci_reg == '0) || (!rev_reg && last_sec
                                && !rev_mode_reg))
                            begin
                                // end of pass: back to the start, flag it
                                ci_reg      <= '0;
                                begin_x_reg <= start_x_reg;
                                begin_y_reg <= start_y_reg;
                                pos_x_reg   <= start_x_reg;
                                pos_y_reg   <= start_y_reg;
                                rev_reg     <= 1'b0;
                                fin_reg     <= 1'b1;
                            end
                            else if (rev_reg)
                            begin
                                ci_reg <= ci_reg - 1'b1;
                            end
                            else if (last_sec)
                            begin
                                rev_reg <= 1'b1;
                            end
                            else
                            begin
                                ci_reg      <= ci_plus[IDX_BITS-1:0];
                                begin_x_reg <= end_x_reg;
                                begin_y_reg <= end_y_reg;
                            end
                        end
                    end
                end
                ST_SEC_B:
                begin
                    if (!rev_reg)
                    begin
                        end_x_reg <= rd_data_reg.x;
                        end_y_reg <= rd_data_reg.y;
                    end
                    else
                    begin
                        begin_x_reg <= rd_data_reg.x;
                        begin_y_reg <= rd_data_reg.y;
                        if (ci_reg == '0)
                        begin
                            end_x_reg <= start_x_reg;
                            end_y_reg <= start_y_reg;
                        end
                    end
                end
                ST_SEC_C:
                begin
                    end_x_reg <= rd_data_reg.x;
                    end_y_reg <= rd_data_reg.y;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign step_x        = step_x_reg;
    assign step_y        = step_y_reg;
    assign position_x    = pos_x_reg;
    assign position_y    = pos_y_reg;
    assign finished      = fin_reg;
    assign going_back    = rev_reg;
    assign section_index = {1'b0, ci_reg};
    assign status        = status_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");
    a_lanes_align: assert property (@(posedge clk) disable iff (!rst_n)
        done_x == done_y)
        else $error("x and y scale units out of step");
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && pc_reg != '0) |-> {1'b0, ci_reg} < pc_reg)
        else $error("section index beyond keypoint count");

endmodule
`default_nettype wire
